[rtl/bws_pkg.sv]
// shared types and constants for the box window sum core detect block
// used by every module of the block; no dependencies
package bws_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned RADIUS_W   = 3;
    localparam int unsigned TOTAL_W    = 40;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS     = 1'b0,
        CFG_MIN_POINTS = 1'b1
    } t_cfg_idx;

    // one result item
    typedef struct packed {
        logic [VALUE_W-1:0] window_sum;
        logic               core;
        logic               result_last;
    } t_result;

endpackage

[rtl/bws_window.sv]
// window shift line, running total and end-of-line flush sequencer
// depends on bws_pkg
module bws_window #(
    parameter int unsigned MAX_RADIUS = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bws_pkg::RADIUS_W-1:0]  i_radius,
    input  logic [bws_pkg::VALUE_W-1:0]   i_min_points,
    input  logic                          i_item_valid,
    input  logic [bws_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_occupied,
    input  logic                          i_line_end,
    input  logic                          i_space,
    output logic                          o_take,
    output logic                          o_push,
    output bws_pkg::t_result              o_result
);
    import bws_pkg::*;

    localparam int unsigned WIN   = 2 * MAX_RADIUS + 1;
    localparam int unsigned WIDX  = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int unsigned CW    = $clog2(WIN + 1);
    localparam logic [4:0]  MAX_R = 5'(MAX_RADIUS);
    localparam logic [CW-1:0] WIN_C = CW'(WIN);

    // window storage: index 0 is the newest value
    logic [VALUE_W-1:0] r_win [WIN];
    logic               r_occ [WIN];
    logic [VALUE_W-1:0] n_win [WIN];
    logic               n_occ [WIN];

    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [CW-1:0]       r_count, n_count;
    logic                r_flush, n_flush;
    logic [RADIUS_W-1:0] r_d, n_d;

    logic [RADIUS_W-1:0] r_eff;
    logic [3:0]          two_r;
    logic [3:0]          flush_idx;
    logic [CW-1:0]       count_inc;
    logic [TOTAL_W-1:0]  main_sub;
    logic [TOTAL_W-1:0]  main_total;
    logic [TOTAL_W-1:0]  flush_total;
    logic                step_main;
    logic                step_flush;

    function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        return (b > a) ? '0 : a - b;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
    endfunction

    function automatic t_result make_result(input logic [TOTAL_W-1:0] tot,
                                            input logic [VALUE_W-1:0] minp,
                                            input logic               occ,
                                            input logic               last);
        t_result res;
        res.window_sum  = (tot[TOTAL_W-1:VALUE_W] != '0) ? '1 : tot[VALUE_W-1:0];
        res.core        = (tot > {{(TOTAL_W-VALUE_W){1'b0}}, minp}) && occ;
        res.result_last = last;
        return res;
    endfunction

    // effective radius, limited to the window depth
    always_comb begin
        if ({2'b00, i_radius} > MAX_R) begin
            r_eff = MAX_R[RADIUS_W-1:0];
        end else begin
            r_eff = i_radius;
        end
        two_r     = {r_eff, 1'b0};
        flush_idx = {1'b0, r_d} + {1'b0, r_eff} + 4'd1;
        count_inc = (r_count < WIN_C) ? r_count + CW'(1) : r_count;
    end

    // shifted window for a new value
    always_comb begin
        n_win[0] = i_value;
        n_occ[0] = i_occupied;
        for (int i = 1; i < WIN; i++) begin
            n_win[i] = r_win[i-1];
            n_occ[i] = r_occ[i-1];
        end
    end

    // running total updates: drop the leaving value, add the new one
    always_comb begin
        if (32'(r_count) > 32'(two_r)) begin
            main_sub = sat_sub(r_total, {{(TOTAL_W-VALUE_W){1'b0}}, r_win[WIDX'(two_r)]});
        end else begin
            main_sub = r_total;
        end
        main_total = sat_add(main_sub, {{(TOTAL_W-VALUE_W){1'b0}}, i_value});
        if (32'(flush_idx) < 32'(r_count)) begin
            flush_total = sat_sub(r_total,
                                  {{(TOTAL_W-VALUE_W){1'b0}}, r_win[WIDX'(flush_idx)]});
        end else begin
            flush_total = r_total;
        end
    end

    assign step_main  = i_item_valid && !r_flush && i_space;
    assign step_flush = r_flush && i_space;

    // next state of total, count and flush sequencer
    always_comb begin
        n_total = r_total;
        n_count = r_count;
        n_flush = r_flush;
        n_d     = r_d;
        if (step_main) begin
            n_total = main_total;
            n_count = count_inc;
            if (i_line_end) begin
                if (r_eff == '0) begin
                    n_total = '0;
                    n_count = '0;
                end else begin
                    n_flush = 1'b1;
                    n_d     = r_eff - RADIUS_W'(1);
                end
            end
        end else if (step_flush) begin
            n_total = flush_total;
            if (r_d == '0) begin
                n_total = '0;
                n_count = '0;
                n_flush = 1'b0;
            end else begin
                n_d = r_d - RADIUS_W'(1);
            end
        end
    end

    // result push toward the output buffer
    always_comb begin
        o_take   = step_main;
        o_push   = 1'b0;
        o_result = make_result(main_total, i_min_points, n_occ[WIDX'(r_eff)],
                               i_line_end && (r_eff == '0));
        if (step_main) begin
            o_push = 32'(count_inc) > 32'(r_eff);
        end else if (step_flush) begin
            o_push   = 32'(r_count) > 32'(r_d);
            o_result = make_result(flush_total, i_min_points, r_occ[WIDX'(r_d)],
                                   r_d == '0);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_count <= '0;
            r_flush <= 1'b0;
            r_d     <= '0;
        end else begin
            r_total <= n_total;
            r_count <= n_count;
            r_flush <= n_flush;
            r_d     <= n_d;
        end
    end

    // window payload, only entries below the count are ever read
    always_ff @(posedge i_clk) begin
        if (step_main) begin
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= n_win[i];
                r_occ[i] <= n_occ[i];
            end
        end
    end

endmodule

[rtl/bws_out_buf.sv]
// two-entry result buffer: output register plus skid entry
// depends on bws_pkg
module bws_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bws_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    output bws_pkg::t_result o_data,
    input  logic             i_stall
);
    import bws_pkg::*;

    t_result    r_q0, r_q1;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_space = (r_cnt != 2'd2) || pop;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_q0;

    // occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push && !pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // entry data, head always in r_q0
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
                if (i_push) begin
                    r_q1 <= i_data;
                end
            end else if (i_push) begin
                r_q0 <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_data;
            end else begin
                r_q1 <= i_data;
            end
        end
    end

endmodule

[rtl/box_window_sum_core_detect_core.sv]
// top level of the box window sum core detect block: input register, config, wiring
// depends on bws_pkg, bws_window and bws_out_buf
//
// One axis pass of a separable box filter. Values of a line stream in one item per
// cycle while the block does not stall its input, and each gives at most one window
// sum, which comes out once radius further values have arrived; the sum is saturated
// to 32 bits and core is set when it exceeds min_points and the centre bin is
// occupied. After an item with line_end set, the remaining results, up to radius of
// them, are flushed one per cycle by the flush sequencer while input stalls and the
// result buffer has space. A result passes through the input register and then the
// result buffer before it is valid on the output. The window depth is
// 2*MAX_RADIUS+1; radius values above MAX_RADIUS act as MAX_RADIUS. Write the
// configuration only while the block is idle.
module box_window_sum_core_detect_core #(
    parameter int unsigned MAX_RADIUS = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bws_pkg::VALUE_W-1:0]     i_value,
    input  logic                            i_occupied,
    input  logic                            i_line_end,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bws_pkg::VALUE_W-1:0]     o_window_sum,
    output logic                            o_core,
    output logic                            o_result_last,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [bws_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bws_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bws_pkg::*;

    logic [RADIUS_W-1:0] r_radius;
    logic [VALUE_W-1:0]  r_min_points;

    logic               r_in_valid;
    logic [VALUE_W-1:0] r_value;
    logic               r_occupied;
    logic               r_line_end;

    logic    take;
    logic    push;
    logic    space;
    logic    accept;
    t_result win_result;
    t_result out_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_W'(1);
            r_min_points <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RADIUS: begin
                    r_radius <= i_cfg_data[RADIUS_W-1:0];
                end
                CFG_MIN_POINTS: begin
                    r_min_points <= i_cfg_data[VALUE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    assign o_in_stall = r_in_valid && !take;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value    <= i_value;
            r_occupied <= i_occupied;
            r_line_end <= i_line_end;
        end
    end

    // window and running sum
    bws_window #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_radius     (r_radius),
        .i_min_points (r_min_points),
        .i_item_valid (r_in_valid),
        .i_value      (r_value),
        .i_occupied   (r_occupied),
        .i_line_end   (r_line_end),
        .i_space      (space),
        .o_take       (take),
        .o_push       (push),
        .o_result     (win_result)
    );

    // result buffer
    bws_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (win_result),
        .o_space (space),
        .o_valid (o_out_valid),
        .o_data  (out_result),
        .i_stall (i_out_stall)
    );

    assign o_window_sum  = out_result.window_sum;
    assign o_core        = out_result.core;
    assign o_result_last = out_result.result_last;

endmodule
